// ----- rtl/eept_pkg.sv -----
// Shared types and constants for the encoder edge period tracker.
package eept_pkg;

   localparam int unsigned TIME_W  = 64;
   localparam int unsigned TALLY_W = 32;
   localparam int unsigned REFR_W  = 32;
   localparam int unsigned TGT_W   = 16;
   localparam int unsigned CSR_AW  = 2;
   localparam int unsigned CSR_DW  = 32;

   localparam logic [REFR_W-1:0]  REFRACTORY_RESET = REFR_W'(10000);
   localparam logic [TALLY_W-1:0] TALLY_MAX        = '1;

   // command codes
   localparam logic CMD_EDGE    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_REFRACTORY = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_CAL_MODE   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_TARGET     = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic              channel;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic [TIME_W-1:0]  interval_sum_us;
      logic [TALLY_W-1:0] interval_count;
      logic [TALLY_W-1:0] edges_seen;
      logic [TIME_W-1:0]  first_edge_us;
      logic [TIME_W-1:0]  target_edge_us;
      logic               cal_complete;
   } rsp_type;

   typedef struct packed {
      logic [REFR_W-1:0] refractory_us;
      logic              calibrate_mode;
      logic [TGT_W-1:0]  target_edge_count;
   } cfg_type;

   function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
      sat_inc = (v == TALLY_MAX) ? v : v + TALLY_W'(1);
   endfunction

endpackage

// ----- rtl/eept_csr.sv -----
// Configuration registers of the encoder edge period tracker.
module eept_csr
   import eept_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_REFRACTORY: cfg_in.refractory_us     = csr_wdata[REFR_W-1:0];
            CSR_CAL_MODE:   cfg_in.calibrate_mode    = csr_wdata[0];
            CSR_TARGET:     cfg_in.target_edge_count = csr_wdata[TGT_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.refractory_us     <= REFRACTORY_RESET;
         cfg_ff.calibrate_mode    <= 1'b0;
         cfg_ff.target_edge_count <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/eept_track.sv -----
// Per-channel interval state and calibration capture, updated once per word.
module eept_track
   import eept_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [TIME_W-1:0]  last_time_ff [2];
   logic [TIME_W-1:0]  last_time_in [2];
   logic [TIME_W-1:0]  sum_ff       [2];
   logic [TIME_W-1:0]  sum_in       [2];
   logic [TALLY_W-1:0] tally_ff     [2];
   logic [TALLY_W-1:0] tally_in     [2];
   logic [TALLY_W-1:0] edges_ff;
   logic [TALLY_W-1:0] edges_in;
   logic [TIME_W-1:0]  first_ff;
   logic [TIME_W-1:0]  first_in;
   logic [TIME_W-1:0]  target_ff;
   logic [TIME_W-1:0]  target_in;

   logic [TIME_W-1:0]  delta;
   logic               pass;
   logic               acc;

   // interval wraps modulo 2^64, so a backwards timestamp normally passes
   assign delta = item.time_us - last_time_ff[item.channel];
   assign pass  = delta >= {{(TIME_W-REFR_W){1'b0}}, cfg.refractory_us};

   always_comb begin
      last_time_in = last_time_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      edges_in     = edges_ff;
      first_in     = first_ff;
      target_in    = target_ff;
      acc          = 1'b0;
      if (item.cmd == CMD_RESTART) begin
         for (int i = 0; i < 2; i++) begin
            last_time_in[i] = item.time_us;
            sum_in[i]       = '0;
            tally_in[i]     = '0;
         end
         edges_in = '0;
      end else if (cfg.calibrate_mode) begin
         if (edges_ff == '0)
            first_in = item.time_us;
         if (edges_ff == {{(TALLY_W-TGT_W){1'b0}}, cfg.target_edge_count})
            target_in = item.time_us;
         edges_in = sat_inc(edges_ff);
         acc      = 1'b1;
      end else if (pass) begin
         last_time_in[item.channel] = item.time_us;
         sum_in[item.channel]       = sum_ff[item.channel] + delta;
         tally_in[item.channel]     = sat_inc(tally_ff[item.channel]);
         acc                        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            last_time_ff[i] <= '0;
            sum_ff[i]       <= '0;
            tally_ff[i]     <= '0;
         end
         edges_ff  <= '0;
         first_ff  <= '0;
         target_ff <= '0;
      end else if (fire) begin
         last_time_ff <= last_time_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         edges_ff     <= edges_in;
         first_ff     <= first_in;
         target_ff    <= target_in;
      end
   end

   always_comb begin
      result.accepted        = acc;
      result.interval_sum_us = sum_in[item.channel];
      result.interval_count  = tally_in[item.channel];
      result.edges_seen      = edges_in;
      result.first_edge_us   = first_in;
      result.target_edge_us  = target_in;
      result.cal_complete    = edges_in > {{(TALLY_W-TGT_W){1'b0}}, cfg.target_edge_count};
   end

endmodule

// ----- rtl/encoder_edge_period_tracker_core.sv -----
// Top level of the encoder edge period tracker: input and result registers around the update.
//
//   channel | ports                         | direction | payload
//   --------+-------------------------------+-----------+-------------------------
//   request | req_valid/req_ready/req_data  | in        | cmd, channel, time_us
//   result  | rsp_valid/rsp_ready/rsp_data  | out       | one result word per request
//   config  | csr_we/csr_addr/csr_wdata     | in        | write only, no wait
//
// One word per cycle sustained while rsp_ready is high; rsp_valid rises at the edge that
// moves the word from the input register into the result register. The state update
// sits between them. Synchronous active-high reset clears control, tracking state and
// config. When rsp_ready is low both stages hold and req_ready drops once full.
module encoder_edge_period_tracker_core
   import eept_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type result;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    advance;
   logic    fire;

   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   eept_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   eept_track u_track (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready)
            in_valid_ff <= req_valid;
         if (advance)
            out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid)
         in_data_ff <= req_data;
      if (fire)
         out_data_ff <= result;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
